// ===== hdl/det_pkg.sv =====
// ----------------------------------------------------------------------------
// Directory entry table package
// Shared sizes, codes and types of the directory entry table.
// ----------------------------------------------------------------------------
package det_pkg;

  localparam int NUM_SLOTS  = 16;
  localparam int AW         = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW         = $clog2(NUM_SLOTS + 1);
  localparam int NAME_PARTS = 4;
  localparam int PART_W     = 56;
  localparam int NAME_BYTES = NAME_PARTS * PART_W / 8;
  localparam int INODE_W    = 16;
  localparam int IDX_W      = 6;
  localparam int STATUS_W   = 3;
  localparam int USED_W     = 6;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_DELETE = 1'b1
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_EXISTS    = 3'd1,
    ST_FULL      = 3'd2,
    ST_NEG_INODE = 3'd3,
    ST_RANGE     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_DEL,
    S_DONE
  } state_t;

  typedef logic [NAME_PARTS*PART_W-1:0] name_t;

  typedef struct packed {
    name_t              name;
    logic [INODE_W-1:0] inode;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    entry_t        wdata;
    logic [AW-1:0] raddr;
  } mem_req_t;

endpackage

// ===== hdl/det_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module det_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/det_canon.sv =====
// ----------------------------------------------------------------------------
// Name canonicaliser
// Clears every byte after the first zero byte of a name and holds the result.
// ----------------------------------------------------------------------------
module det_canon (
  input  logic          clk,
  input  logic          load,
  input  det_pkg::name_t raw,
  output det_pkg::name_t name
);

  logic [det_pkg::NAME_BYTES-1:0] zero_flag;
  logic [det_pkg::NAME_BYTES-1:0] keep;
  det_pkg::name_t                 canon;
  det_pkg::name_t                 name_r;

  always_comb begin
    for (int b = 0; b < det_pkg::NAME_BYTES; b++) begin
      zero_flag[b] = (raw[8*b +: 8] == 8'h00);
    end
    for (int b = 0; b < det_pkg::NAME_BYTES; b++) begin
      keep[b] = 1'b1;
      for (int j = 0; j <= b; j++) begin
        if (zero_flag[j]) begin
          keep[b] = 1'b0;
        end
      end
      canon[8*b +: 8] = keep[b] ? raw[8*b +: 8] : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      name_r <= canon;
    end
  end

  assign name = name_r;

endmodule

// ===== hdl/det_ctrl.sv =====
// ----------------------------------------------------------------------------
// Directory entry table sequencer
// Scans, writes back and shifts slots in the table memory, one per cycle.
// ----------------------------------------------------------------------------
module det_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  det_pkg::mode_t                in_mode,
  input  logic [det_pkg::INODE_W-1:0]   in_inode,
  input  logic [det_pkg::IDX_W-1:0]     in_idx,
  input  det_pkg::name_t                name,
  output det_pkg::mem_req_t             mem,
  input  det_pkg::entry_t               mem_rdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output det_pkg::status_t              out_status,
  output logic [det_pkg::USED_W-1:0]    out_used
);

  localparam logic [det_pkg::CW-1:0] LAST_PTR = det_pkg::CW'(det_pkg::NUM_SLOTS);

  det_pkg::state_t                  state_r, state_nxt;
  logic [det_pkg::INODE_W-1:0]      inode_r;
  logic [det_pkg::CW-1:0]           rd_ptr_r, rd_ptr_nxt;
  logic                             cmp_vld_r, cmp_vld_nxt;
  logic [det_pkg::AW-1:0]           cmp_addr_r, cmp_addr_nxt;
  logic                             rd_valid_r, rd_valid_nxt;
  logic [det_pkg::NUM_SLOTS-1:0]    valid_r, valid_nxt;
  logic                             exists_r, exists_nxt;
  logic                             found_r, found_nxt;
  logic [det_pkg::AW-1:0]           free_r, free_nxt;
  det_pkg::status_t                 status_r, status_nxt;
  logic [det_pkg::AW-1:0]           used_r, used_nxt;
  logic                             out_valid_r, out_valid_nxt;
  det_pkg::status_t                 out_status_r;
  logic [det_pkg::USED_W-1:0]       out_used_r;

  logic                             accept;
  logic                             rd_issue;
  logic                             sweep_done;
  logic                             out_free;
  logic                             idx_bad;
  det_pkg::entry_t                  entry;

  assign accept     = in_tvalid && in_tready;
  assign in_tready  = (state_r == det_pkg::S_IDLE);
  assign rd_issue   = ((state_r == det_pkg::S_SCAN) || (state_r == det_pkg::S_DEL)) &&
                      (rd_ptr_r < LAST_PTR);
  assign sweep_done = (rd_ptr_r == LAST_PTR) && !cmp_vld_r;
  assign out_free   = !out_valid_r || out_tready;
  assign idx_bad    = ({1'b0, in_idx} >= (det_pkg::IDX_W + 1)'(det_pkg::NUM_SLOTS));
  assign entry      = rd_valid_r ? mem_rdata : '0;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      det_pkg::S_IDLE: begin
        if (accept) begin
          if (in_mode == det_pkg::MODE_INSERT) begin
            state_nxt = in_inode[det_pkg::INODE_W-1] ? det_pkg::S_DONE : det_pkg::S_SCAN;
          end else begin
            state_nxt = idx_bad ? det_pkg::S_DONE : det_pkg::S_DEL;
          end
        end
      end
      det_pkg::S_SCAN: begin
        if (sweep_done) begin
          state_nxt = (exists_r || !found_r) ? det_pkg::S_DONE : det_pkg::S_WRITE;
        end
      end
      det_pkg::S_WRITE: state_nxt = det_pkg::S_DONE;
      det_pkg::S_DEL: begin
        if (sweep_done) begin
          state_nxt = det_pkg::S_DONE;
        end
      end
      det_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = det_pkg::S_IDLE;
        end
      end
      default: state_nxt = det_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    rd_ptr_nxt    = rd_ptr_r;
    cmp_vld_nxt   = 1'b0;
    cmp_addr_nxt  = cmp_addr_r;
    rd_valid_nxt  = rd_valid_r;
    valid_nxt     = valid_r;
    exists_nxt    = exists_r;
    found_nxt     = found_r;
    free_nxt      = free_r;
    status_nxt    = status_r;
    used_nxt      = used_r;
    out_valid_nxt = out_valid_r && !out_tready;
    mem.we        = 1'b0;
    mem.waddr     = cmp_addr_r;
    mem.wdata     = entry;
    mem.raddr     = rd_ptr_r[det_pkg::AW-1:0];

    if (rd_issue) begin
      rd_ptr_nxt   = rd_ptr_r + 1'b1;
      cmp_vld_nxt  = 1'b1;
      cmp_addr_nxt = rd_ptr_r[det_pkg::AW-1:0];
      rd_valid_nxt = valid_r[rd_ptr_r[det_pkg::AW-1:0]];
    end

    unique case (state_r)
      det_pkg::S_IDLE: begin
        status_nxt = det_pkg::ST_OK;
        used_nxt   = '0;
        exists_nxt = 1'b0;
        found_nxt  = 1'b0;
        free_nxt   = '0;
        if (accept) begin
          if (in_mode == det_pkg::MODE_INSERT) begin
            rd_ptr_nxt = '0;
            if (in_inode[det_pkg::INODE_W-1]) begin
              status_nxt = det_pkg::ST_NEG_INODE;
            end
          end else begin
            rd_ptr_nxt = det_pkg::CW'(in_idx) + 1'b1;
            if (idx_bad) begin
              status_nxt = det_pkg::ST_RANGE;
            end
          end
        end
      end
      det_pkg::S_SCAN: begin
        if (cmp_vld_r) begin
          if (entry.name == name) begin
            exists_nxt = 1'b1;
          end
          if (!found_r && (entry.inode == '0)) begin
            found_nxt = 1'b1;
            free_nxt  = cmp_addr_r;
          end
        end
        if (sweep_done) begin
          if (exists_r) begin
            status_nxt = det_pkg::ST_EXISTS;
          end else if (!found_r) begin
            status_nxt = det_pkg::ST_FULL;
          end
        end
      end
      det_pkg::S_WRITE: begin
        mem.we            = 1'b1;
        mem.waddr         = free_r;
        mem.wdata.name    = name;
        mem.wdata.inode   = inode_r;
        valid_nxt[free_r] = 1'b1;
        used_nxt          = free_r;
      end
      det_pkg::S_DEL: begin
        if (cmp_vld_r) begin
          mem.we                  = 1'b1;
          mem.waddr               = cmp_addr_r - 1'b1;
          valid_nxt[mem.waddr]    = 1'b1;
        end
        if (sweep_done) begin
          valid_nxt[det_pkg::NUM_SLOTS-1] = 1'b0;
        end
      end
      det_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= det_pkg::S_IDLE;
      cmp_vld_r   <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr_r   <= rd_ptr_nxt;
    cmp_addr_r <= cmp_addr_nxt;
    rd_valid_r <= rd_valid_nxt;
    exists_r   <= exists_nxt;
    found_r    <= found_nxt;
    free_r     <= free_nxt;
    status_r   <= status_nxt;
    used_r     <= used_nxt;
    if (accept) begin
      inode_r <= in_inode;
    end
    if ((state_r == det_pkg::S_DONE) && out_free) begin
      out_status_r <= status_r;
      out_used_r   <= det_pkg::USED_W'(used_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_status = out_status_r;
  assign out_used   = out_used_r;

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem.we && rd_issue) |-> (mem.waddr != mem.raddr))
    else $error("table write hits the entry being read");

  a_used_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_used_r != '0)) |-> (out_status_r == det_pkg::ST_OK))
    else $error("slot reported for a refused transaction");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (valid_r == '0) && !out_valid_r)
    else $error("table not cleared by reset");

  a_last_emptied: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == det_pkg::S_DEL) && sweep_done) |=> !valid_r[det_pkg::NUM_SLOTS-1])
    else $error("last slot not emptied after delete");

  a_cmp_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_vld_r |-> ((state_r == det_pkg::S_SCAN) || (state_r == det_pkg::S_DEL)))
    else $error("read data pending outside a sweep");

endmodule

// ===== hdl/directory_entry_table_core.sv =====
// ----------------------------------------------------------------------------
// Directory entry table
// Table of named directory slots with insert-by-name and delete-by-index.
// ----------------------------------------------------------------------------
// The input channel carries one command per transaction. in_tuser selects the
// operation: zero inserts the name and inode number in in_tdata, one deletes
// the slot given by the slot index. Every command yields exactly one result
// transaction on the output channel with a status code and, after a
// successful insert, the slot that was written.
// The slots live in one memory with registered read. An insert sweeps all
// NUM_SLOTS entries, one read a cycle, comparing names and looking for the
// first free slot, then writes the chosen slot if the name is new and a slot
// is free. A delete reads each later slot and writes it one place down in the
// same sweep, then empties the last slot. One command is processed at a time.
// Reset empties every slot at once through per-slot valid flags.
// The result sits in an output register; a new command is accepted while an
// earlier result waits, and the block holds before answering only if the
// receiver still has not taken the previous result.
// ----------------------------------------------------------------------------
module directory_entry_table_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // name_word0, name_word1, name_word2, name_word3, inode_number, slot_index
  input  logic [247:0] in_tdata,
  // mode
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status, slot_used
  output logic [15:0]  out_tdata
);

  det_pkg::name_t                raw_name;
  det_pkg::name_t                name;
  det_pkg::mem_req_t             mem;
  logic [det_pkg::ENTRY_W-1:0]   mem_rdata;
  det_pkg::status_t              status;
  logic [det_pkg::USED_W-1:0]    used;

  assign raw_name = in_tdata[223:0];

  det_canon u_canon (
    .clk  (clk),
    .load (in_tvalid && in_tready),
    .raw  (raw_name),
    .name (name)
  );

  det_ram #(
    .WIDTH (det_pkg::ENTRY_W),
    .DEPTH (det_pkg::NUM_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .raddr (mem.raddr),
    .rdata (mem_rdata)
  );

  det_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_mode    (det_pkg::mode_t'(in_tuser[0])),
    .in_inode   (in_tdata[239:224]),
    .in_idx     (in_tdata[245:240]),
    .name       (name),
    .mem        (mem),
    .mem_rdata  (det_pkg::entry_t'(mem_rdata)),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_status (status),
    .out_used   (used)
  );

  assign out_tdata = {7'b0, used, status};

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Directory entry table testbench
// Drives insert and delete commands into the directory entry table over the
// input stream and checks every result transaction against a table model
// kept here. Directed tests cover the special cases. Random phases then mix
// well-formed traffic from a small name pool, which forces name clashes and
// full tables, with raw noise. Either side idles at random in some phases.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    det_pkg::status_t             status;
    logic [det_pkg::USED_W-1:0]   slot;
  } dir_result_t;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [247:0] in_tdata   = '0;
  logic [0:0]   in_tuser   = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [15:0]  out_tdata;

  det_pkg::name_t              tbl_name  [det_pkg::NUM_SLOTS] = '{default: '0};
  logic [det_pkg::INODE_W-1:0] tbl_inode [det_pkg::NUM_SLOTS] = '{default: '0};
  dir_result_t                 pending_results [$];
  det_pkg::name_t              name_pool [24];
  int                          fail_count = 0;
  bit                          tx_idle_en = 1'b0;
  bit                          rx_idle_en = 1'b0;
  int                          rx_hold    = 0;

  directory_entry_table_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int gap_len();
    if ($urandom_range(99) < 85) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic det_pkg::name_t random_bits();
    det_pkg::name_t n;
    for (int k = 0; k < det_pkg::NAME_BYTES / 4; k++) begin
      n[32*k +: 32] = $urandom;
    end
    return n;
  endfunction

  // Builds a name of the given length; junk bytes may follow the terminator.
  function automatic det_pkg::name_t make_name(int len, bit junk);
    det_pkg::name_t n;
    n = '0;
    for (int k = 0; k < det_pkg::NAME_BYTES; k++) begin
      if (k < len) begin
        n[8*k +: 8] = 8'($urandom_range(1, 255));
      end else if (k > len && junk) begin
        n[8*k +: 8] = 8'($urandom);
      end
    end
    return n;
  endfunction

  function automatic dir_result_t predict_directory(det_pkg::mode_t m,
                                                    det_pkg::name_t raw,
                                                    logic [det_pkg::INODE_W-1:0] ino,
                                                    logic [det_pkg::IDX_W-1:0] idx);
    dir_result_t    r;
    det_pkg::name_t nm;
    bit             ended;
    bit             exists;
    bit             found;
    int             free_slot;
    r.status  = det_pkg::ST_OK;
    r.slot    = '0;
    nm        = '0;
    ended     = 1'b0;
    exists    = 1'b0;
    found     = 1'b0;
    free_slot = 0;
    if (m == det_pkg::MODE_INSERT) begin
      if (ino[det_pkg::INODE_W-1]) begin
        r.status = det_pkg::ST_NEG_INODE;
      end else begin
        for (int k = 0; k < det_pkg::NAME_BYTES; k++) begin
          if (raw[8*k +: 8] == 8'h00) ended = 1'b1;
          if (!ended) nm[8*k +: 8] = raw[8*k +: 8];
        end
        for (int i = 0; i < det_pkg::NUM_SLOTS; i++) begin
          if (tbl_name[i] == nm) exists = 1'b1;
          if (!found && tbl_inode[i] == '0) begin
            found     = 1'b1;
            free_slot = i;
          end
        end
        if (exists) begin
          r.status = det_pkg::ST_EXISTS;
        end else if (!found) begin
          r.status = det_pkg::ST_FULL;
        end else begin
          tbl_name[free_slot]  = nm;
          tbl_inode[free_slot] = ino;
          r.slot               = det_pkg::USED_W'(free_slot);
        end
      end
    end else begin
      if (idx >= det_pkg::NUM_SLOTS) begin
        r.status = det_pkg::ST_RANGE;
      end else begin
        for (int i = int'(idx) + 1; i < det_pkg::NUM_SLOTS; i++) begin
          tbl_name[i-1]  = tbl_name[i];
          tbl_inode[i-1] = tbl_inode[i];
        end
        tbl_name[det_pkg::NUM_SLOTS-1]  = '0;
        tbl_inode[det_pkg::NUM_SLOTS-1] = '0;
      end
    end
    return r;
  endfunction

  // Called at a rising edge; returns at the edge that accepts the command.
  task automatic send_command(det_pkg::mode_t m, det_pkg::name_t nm,
                              logic [det_pkg::INODE_W-1:0] ino,
                              logic [det_pkg::IDX_W-1:0] idx);
    int gap;
    gap = (tx_idle_en && $urandom_range(99) < 35) ? gap_len() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= m;
    in_tdata  <= {2'b00, idx, ino, nm};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_directory(m, nm, ino, idx));
  endtask

  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      out_tready <= 1'b0;
    end else if (rx_idle_en && $urandom_range(99) < 20) begin
      rx_hold = gap_len() - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    dir_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: status %0d, slot_used %0d",
               out_tdata[2:0], out_tdata[8:3]);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[2:0] !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_tdata[2:0]);
          fail_count++;
        end
        if (out_tdata[8:3] !== want.slot) begin
          $error("slot_used: expected %0d, actual %0d", want.slot, out_tdata[8:3]);
          fail_count++;
        end
      end
    end
  end

  task automatic test_insert_cases();
    det_pkg::name_t nm;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    send_command(det_pkg::MODE_INSERT, '0, 16'd5, '0);
    send_command(det_pkg::MODE_INSERT, make_name(3, 1'b0), 16'h8000, 6'h3F);
    send_command(det_pkg::MODE_INSERT, '1, 16'hFFFF, '0);
    send_command(det_pkg::MODE_INSERT, '1, 16'h7FFF, 6'h3F);
    nm = random_bits();
    nm[7:0]  = 8'h42;
    nm[15:8] = 8'h00;
    send_command(det_pkg::MODE_INSERT, nm, 16'd1, '0);
    send_command(det_pkg::MODE_INSERT, det_pkg::name_t'(8'h42), 16'd2, '0);
    send_command(det_pkg::MODE_INSERT, make_name(4, 1'b0), 16'd0, '0);
    send_command(det_pkg::MODE_INSERT, make_name(5, 1'b1), 16'd9, '0);
    for (int i = 0; i < det_pkg::NUM_SLOTS - 3; i++) begin
      nm = '0;
      nm[7:0]  = 8'h66;
      nm[15:8] = 8'(8'h30 + i);
      send_command(det_pkg::MODE_INSERT, nm, 16'(i + 10), '0);
    end
    send_command(det_pkg::MODE_INSERT, make_name(6, 1'b0), 16'd3, '0);
    send_command(det_pkg::MODE_INSERT, det_pkg::name_t'(8'h42), 16'd3, '0);
  endtask

  task automatic test_delete_cases();
    send_command(det_pkg::MODE_DELETE, '0, '0, 6'd16);
    send_command(det_pkg::MODE_DELETE, '1, '1, 6'd63);
    send_command(det_pkg::MODE_DELETE, '0, '0, 6'd15);
    send_command(det_pkg::MODE_DELETE, '0, '0, 6'd0);
    send_command(det_pkg::MODE_DELETE, random_bits(), 16'($urandom), 6'd7);
  endtask

  task automatic test_random_traffic(int count, bit tx_idle, bit rx_idle);
    int                          len;
    int                          pick;
    det_pkg::name_t              nm;
    logic [det_pkg::INODE_W-1:0] ino;
    tx_idle_en = tx_idle;
    rx_idle_en = rx_idle;
    foreach (name_pool[p]) begin
      pick = $urandom_range(99);
      len  = (pick < 80) ? $urandom_range(1, 6) :
             (pick < 95) ? $urandom_range(7, det_pkg::NAME_BYTES - 1) :
                           det_pkg::NAME_BYTES;
      name_pool[p] = make_name(len, 1'b0);
    end
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        send_command(det_pkg::mode_t'($urandom_range(1)), random_bits(),
                     16'($urandom), 6'($urandom));
      end else if (pick < 55) begin
        nm = name_pool[$urandom_range(23)];
        if ($urandom_range(3) == 0) begin
          for (int k = 0; k < det_pkg::NAME_BYTES; k++) begin
            if (nm[8*k +: 8] == 8'h00) begin
              nm[8*k +: 8] = 8'h00;
              if (k + 1 < det_pkg::NAME_BYTES) nm[8*(k+1) +: 8] = 8'($urandom);
              break;
            end
          end
        end
        pick = $urandom_range(99);
        ino  = (pick < 85) ? 16'($urandom_range(1, 32767)) :
               (pick < 90) ? 16'd0 : 16'($urandom_range(32768, 65535));
        send_command(det_pkg::MODE_INSERT, nm, ino, 6'($urandom));
      end else begin
        send_command(det_pkg::MODE_DELETE, random_bits(), 16'($urandom),
                     ($urandom_range(99) < 80) ?
                       6'($urandom_range(det_pkg::NUM_SLOTS - 1)) : 6'($urandom));
      end
    end
  endtask

  task automatic test_pause_until_drained();
    wait_all_results();
    repeat ($urandom_range(1, 10)) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_insert_cases();
    test_delete_cases();
    test_random_traffic(120, 1'b0, 1'b0);
    test_random_traffic(250, 1'b1, 1'b1);
    test_pause_until_drained();
    test_random_traffic(150, 1'b1, 1'b0);
    test_random_traffic(130, 1'b0, 1'b1);
    wait_all_results();
    repeat (4 * det_pkg::NUM_SLOTS) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/det_pkg.sv
hdl/det_ram.sv
hdl/det_canon.sv
hdl/det_ctrl.sv
hdl/directory_entry_table_core.sv
dv/testbench.sv
